// ===== hw/rtl/region_table_first_fit_allocator_core_defines.svh =====
// Assertion helpers for the region table allocator.
`ifndef REGION_TABLE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define REGION_TABLE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTFFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rtffa_pkg.sv =====
package rtffa_pkg;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = 12;
    localparam int GUARD_PAGES = 1;

    localparam logic [63:0] BASE_RESET  = 64'h0000_0009_0000_0000;
    localparam logic [63:0] LIMIT_RESET = 64'h0000_000A_0000_0000;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_SPACE = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_WINDOW_BASE  = 2'd0;
    localparam t_cfg_index CFG_WINDOW_LIMIT = 2'd1;

    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_RELEASE  = 1'b1;
endpackage

// ===== hw/rtl/region_table_first_fit_allocator_core.sv =====
// First-fit address range allocator over a sorted region table.
// Input channel (i_in_valid / o_in_stall) carries one transaction per request:
// action 0 allocates i_length bytes (rounded up to 4 KiB pages, one guard page
// kept after every region), action 1 releases every region wholly inside
// [i_address, i_address + i_length).
// Output channel (o_out_valid / i_out_stall) returns one transaction per
// request: granted address (0 on error or release), status, and regions held.
// Config channel (i_cfg_valid / o_cfg_ready) writes window_base (index 0) or
// window_limit (index 1); it is always ready and must only be used when idle.
// The table lives in one memory with a registered read port.
// Allocate scans the entries in order until a gap fits, then shifts the
// later entries up one slot and writes the new one; release walks every
// entry and compacts the ones kept. One request is worked on at a time;
// o_in_stall is high while a request is in flight.
// A finished result waits in the output register while i_out_stall is high;
// the next request is taken meanwhile but its result holds until the
// register drains.
// Reset empties the table (count to zero) and loads the default window.
module region_table_first_fit_allocator_core #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic [ADDR_BITS-1:0]                  i_address,
    input  logic [ADDR_BITS-1:0]                  i_length,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ADDR_BITS-1:0]                  o_granted_address,
    output logic [1:0]                            o_status,
    output logic [$clog2(MAX_REGIONS+1)-1:0]      o_entries_in_use,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [ADDR_BITS-1:0]                  i_cfg_data
);
    `include "region_table_first_fit_allocator_core_defines.svh"

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS+1);
    localparam int W  = ADDR_BITS + 2;
    localparam int DW = 2 * ADDR_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
    localparam logic [W-1:0]  PAGE_M1 = W'(rtffa_pkg::PAGE_BYTES - 1);
    localparam logic [W-1:0]  GUARD   =
        W'(rtffa_pkg::GUARD_PAGES * rtffa_pkg::PAGE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_SC_RD, S_SC_EV, S_FIT, S_SH_RD, S_SH_WR, S_INS,
        S_RL_RD, S_RL_EV, S_DONE
    } t_state;

    t_state               r_state;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_len;
    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_limit;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_keep;
    logic [W-1:0]         r_cand;
    logic [W-1:0]         r_need;
    logic [W-1:0]         r_top;
    logic                 r_gap;
    logic [ADDR_BITS-1:0] r_res_addr;
    logic [1:0]           r_res_status;
    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [1:0]           r_out_status;
    logic [CW-1:0]        r_out_count;

    // Region table memory: {length, begin}
    logic [DW-1:0]        mem [MAX_REGIONS];
    logic [DW-1:0]        r_rdata;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    logic [W-1:0]         rd_begin;
    logic [W-1:0]         rd_len;
    logic [W-1:0]         rd_end;
    logic [W-1:0]         rd_next;
    logic [W-1:0]         limit_w;
    logic [W-1:0]         in_len_w;
    logic [CW-1:0]        idx_m1;
    logic                 keep_it;
    logic                 gap_here;
    logic                 fit_ok;
    logic                 out_free;

    assign rd_begin = W'(r_rdata[ADDR_BITS-1:0]);
    assign rd_len   = W'(r_rdata[DW-1:ADDR_BITS]);
    assign rd_end   = rd_begin + rd_len;
    assign rd_next  = ((rd_end + PAGE_M1) & ~PAGE_M1) + GUARD;
    assign limit_w  = W'(r_limit);
    assign in_len_w = W'(i_length);
    assign idx_m1   = r_idx - CW'(1);
    assign keep_it  = !((rd_begin >= W'(r_addr)) && (rd_end <= r_top));
    assign gap_here = (rd_begin > r_cand) && ((rd_begin - r_cand) >= r_need);
    assign fit_ok   = (r_gap || ((limit_w > r_cand) && ((limit_w - r_cand) >= r_need)))
                      && (r_cand != '0);
    assign out_free = !r_out_valid || !i_out_stall;

    // Select memory read address and write enable, address and data from the sequencer state
    always_comb begin
        rd_addr = r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = r_rdata;
        case (r_state)
            S_SH_RD: rd_addr = idx_m1[IW-1:0];
            S_SH_WR: wr_en = 1'b1;
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_data = {r_len, r_cand[ADDR_BITS-1:0]};
            end
            S_RL_EV: begin
                wr_en   = keep_it;
                wr_addr = r_keep[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Sequencer: config writes, scan, shift/insert, compact, and result staging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_base      <= rtffa_pkg::BASE_RESET[ADDR_BITS-1:0];
            r_limit     <= rtffa_pkg::LIMIT_RESET[ADDR_BITS-1:0];
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == rtffa_pkg::CFG_WINDOW_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == rtffa_pkg::CFG_WINDOW_LIMIT) begin
                    r_limit <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_addr       <= i_address;
                        r_len        <= i_length;
                        r_idx        <= '0;
                        r_keep       <= '0;
                        r_cand       <= W'(r_base);
                        r_need       <= (in_len_w + PAGE_M1) & ~PAGE_M1;
                        r_top        <= W'(i_address) + in_len_w;
                        r_gap        <= 1'b0;
                        r_res_addr   <= '0;
                        r_res_status <= rtffa_pkg::ST_OK;
                        r_state      <= (i_action == rtffa_pkg::ACT_RELEASE) ?
                                        S_RL_RD : S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    r_state <= (r_idx < r_count) ? S_SC_EV : S_FIT;
                end
                S_SC_EV: begin
                    if (gap_here) begin
                        r_gap   <= 1'b1;
                        r_state <= S_FIT;
                    end else begin
                        if (rd_next > r_cand) begin
                            r_cand <= rd_next;
                        end
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_FIT: begin
                    // r_idx holds the insert position; restart from the top
                    r_keep <= r_idx;
                    if (!fit_ok) begin
                        r_res_status <= rtffa_pkg::ST_NO_SPACE;
                        r_state      <= S_DONE;
                    end else if (r_count >= MAX_CNT) begin
                        r_res_status <= rtffa_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_idx   <= r_count;
                        r_state <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    if (r_idx > r_keep) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_state <= S_INS;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= idx_m1;
                    r_state <= S_SH_RD;
                end
                S_INS: begin
                    r_count    <= r_count + CW'(1);
                    r_res_addr <= r_cand[ADDR_BITS-1:0];
                    r_state    <= S_DONE;
                end
                S_RL_RD: begin
                    if (r_idx < r_count) begin
                        r_state <= S_RL_EV;
                    end else begin
                        r_count <= r_keep;
                        r_state <= S_DONE;
                    end
                end
                S_RL_EV: begin
                    if (keep_it) begin
                        r_keep <= r_keep + CW'(1);
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_RL_RD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_addr   <= r_res_addr;
                        r_out_status <= r_res_status;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status          = r_out_status;
    assign o_entries_in_use  = r_out_count;

    `RTFFA_ASSERT_NOW(a_count_max, 1'b1, r_count <= MAX_CNT, "region count above capacity")
    `RTFFA_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, r_state != S_IDLE, "request not started")
    `RTFFA_ASSERT_NOW(a_err_zero, o_out_valid && o_status != rtffa_pkg::ST_OK, o_granted_address == '0, "error addr")
    `RTFFA_ASSERT_NEXT(a_full_keep, r_state == S_FIT && r_count >= MAX_CNT, r_state == S_DONE, "insert when full")

endmodule

// ===== verif/tb_region_table_first_fit_allocator_core.sv =====
module tb_region_table_first_fit_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REGIONS = 64;
    localparam int ADDR_BITS   = 48;
    localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);
    localparam int DRAIN_WAIT  = 4 * MAX_REGIONS + 40;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam logic [63:0] ADDR_MAX = (64'd1 << ADDR_BITS) - 64'd1;
    localparam logic [63:0] SAT_MAX  = '1;

    typedef struct {
        logic                 action;
        logic [ADDR_BITS-1:0] address;
        logic [ADDR_BITS-1:0] length;
    } t_request;

    typedef struct {
        logic [ADDR_BITS-1:0] granted;
        rtffa_pkg::t_status   status;
        logic [CNT_BITS-1:0]  count;
    } t_grant;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic [ADDR_BITS-1:0]      i_address;
    logic [ADDR_BITS-1:0]      i_length;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ADDR_BITS-1:0]      o_granted_address;
    logic [1:0]                o_status;
    logic [CNT_BITS-1:0]       o_entries_in_use;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index;
    logic [ADDR_BITS-1:0]      i_cfg_data;

    region_table_first_fit_allocator_core #(
        .MAX_REGIONS(MAX_REGIONS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_address        (i_address),
        .i_length         (i_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_granted_address(o_granted_address),
        .o_status         (o_status),
        .o_entries_in_use (o_entries_in_use),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Shadow allocator state
    logic [63:0] win_base;
    logic [63:0] win_limit;
    logic [63:0] tbl_begin [MAX_REGIONS];
    logic [63:0] tbl_len   [MAX_REGIONS];
    int          tbl_count;

    t_request pending_reqs[$];
    t_grant   grant_q[$];
    t_request cur_req;

    int  fail_cnt;
    int  cycle_cnt;
    int  n_alloc, n_release, n_ok, n_nospace, n_full, max_count;
    int  burst_left, gap_left;
    bit  sender_hold;
    bit  rx_hold_req;
    int  rx_hold_cnt;
    int  rx_mode, rx_mode_left;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? SAT_MAX : s;
    endfunction

    function automatic logic [63:0] round_page(logic [63:0] v);
        logic [63:0] t;
        t = sat_add(v, 64'(rtffa_pkg::PAGE_BYTES - 1));
        if (t == SAT_MAX) return SAT_MAX;
        return t & ~64'(rtffa_pkg::PAGE_BYTES - 1);
    endfunction

    // Compute the result of one request and update the shadow table
    function automatic t_grant allocate_or_release(t_request r);
        t_grant      g;
        logic [63:0] cand, need, b, nxt, top, e, where;
        bit          found, done;
        int          pos, keep;
        g.granted = '0;
        g.status  = rtffa_pkg::ST_OK;
        found = 0;
        done  = 0;
        where = '0;
        if (r.action == rtffa_pkg::ACT_ALLOCATE) begin
            cand = win_base;
            need = round_page(64'(r.length));
            for (int i = 0; i < tbl_count && !done; i++) begin
                b = tbl_begin[i];
                if (b > cand && b - cand >= need) begin
                    where = cand;
                    found = (cand != 0);
                    done  = 1;
                end else begin
                    nxt = sat_add(round_page(sat_add(b, tbl_len[i])),
                                  64'(rtffa_pkg::PAGE_BYTES));
                    if (nxt > cand) cand = nxt;
                end
            end
            if (!done && win_limit > cand && win_limit - cand >= need) begin
                where = cand;
                found = (cand != 0);
            end
            if (!found) begin
                g.status = rtffa_pkg::ST_NO_SPACE;
            end else if (tbl_count >= MAX_REGIONS) begin
                g.status = rtffa_pkg::ST_FULL;
            end else begin
                pos = tbl_count;
                for (int i = tbl_count - 1; i >= 0; i--) begin
                    if (tbl_begin[i] > where) pos = i;
                end
                for (int i = tbl_count; i > pos; i--) begin
                    tbl_begin[i] = tbl_begin[i-1];
                    tbl_len[i]   = tbl_len[i-1];
                end
                tbl_begin[pos] = where;
                tbl_len[pos]   = 64'(r.length);
                tbl_count++;
                g.granted = where[ADDR_BITS-1:0];
            end
        end else begin
            top  = 64'(r.address) + 64'(r.length);
            keep = 0;
            for (int i = 0; i < tbl_count; i++) begin
                b = tbl_begin[i];
                e = b + tbl_len[i];
                if (!(b >= 64'(r.address) && e <= top)) begin
                    tbl_begin[keep] = b;
                    tbl_len[keep]   = tbl_len[i];
                    keep++;
                end
            end
            tbl_count = keep;
        end
        g.count = CNT_BITS'(tbl_count);
        return g;
    endfunction

    // Clock and timeout
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("region_table_first_fit_allocator_core test failed");
            $finish;
        end
    end

    // Request driver: bursts with random gaps, hold payload until taken
    always @(posedge i_clk) begin
        bit       taken;
        t_request nxt;
        taken = 0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                grant_q.push_back(allocate_or_release(cur_req));
                taken = 1;
            end
            if (!i_in_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !sender_hold) begin
                    nxt = pending_reqs.pop_front();
                    cur_req   = nxt;
                    i_action  <= nxt.action;
                    i_address <= nxt.address;
                    i_length  <= nxt.length;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: changing duty pattern, plus a long hold on request
    always @(posedge i_clk) begin
        if (rx_hold_req && rx_hold_cnt == 0) rx_hold_cnt = 900;
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            if (rx_hold_cnt == 0) rx_hold_req = 0;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 400);
            end
            rx_mode_left--;
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= (cycle_cnt % 5 < 2);
            endcase
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grant_q.size() == 0) begin
                $error("result with no pending transaction: addr %0h status %0d",
                       o_granted_address, o_status);
                fail_cnt++;
            end else begin
                g = grant_q.pop_front();
                if (o_granted_address !== g.granted) begin
                    $error("granted_address expected %0h actual %0h",
                           g.granted, o_granted_address);
                    fail_cnt++;
                end
                if (o_status !== g.status) begin
                    $error("status expected %0d actual %0d", g.status, o_status);
                    fail_cnt++;
                end
                if (o_entries_in_use !== g.count) begin
                    $error("entries_in_use expected %0d actual %0d",
                           g.count, o_entries_in_use);
                    fail_cnt++;
                end
                case (g.status)
                    rtffa_pkg::ST_OK:       n_ok++;
                    rtffa_pkg::ST_NO_SPACE: n_nospace++;
                    default:                n_full++;
                endcase
                if (g.count > max_count) max_count = g.count;
            end
        end
    end

    task automatic push_req(logic act, logic [63:0] addr, logic [63:0] len);
        t_request r;
        r.action  = act;
        r.address = addr[ADDR_BITS-1:0];
        r.length  = len[ADDR_BITS-1:0];
        if (act == rtffa_pkg::ACT_ALLOCATE) n_alloc++;
        else n_release++;
        pending_reqs.push_back(r);
    endtask

    // Wait until every transaction has been sent and answered
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || grant_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_window(rtffa_pkg::t_cfg_index idx, logic [63:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val[ADDR_BITS-1:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rtffa_pkg::CFG_WINDOW_BASE) win_base = val & ADDR_MAX;
        else win_limit = val & ADDR_MAX;
    endtask

    task automatic set_window(logic [63:0] base, logic [63:0] limit);
        drain();
        write_window(rtffa_pkg::CFG_WINDOW_BASE, base);
        write_window(rtffa_pkg::CFG_WINDOW_LIMIT, limit);
        @(posedge i_clk);
    endtask

    // Random mix: mostly small allocations and releases near the window base
    task automatic random_phase(int n, int alloc_pct);
        logic [63:0] span, len, addr;
        span = 64'd1 << 20;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                case ($urandom_range(0, 9))
                    0:       len = {$urandom, $urandom} & ADDR_MAX;
                    1, 2:    len = $urandom_range(0, 65536);
                    default: len = $urandom_range(0, 3 * rtffa_pkg::PAGE_BYTES);
                endcase
                push_req(rtffa_pkg::ACT_ALLOCATE, {$urandom, $urandom} & ADDR_MAX, len);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    addr = {$urandom, $urandom} & ADDR_MAX;
                    len  = {$urandom, $urandom} & ADDR_MAX;
                end else begin
                    addr = win_base + ($urandom_range(0, 255) * rtffa_pkg::PAGE_BYTES)
                           - $urandom_range(0, 2);
                    len  = $urandom_range(0, 64'(span) / 4);
                end
                push_req(rtffa_pkg::ACT_RELEASE, addr, len);
            end
        end
    endtask

    initial begin
        fail_cnt = 0; cycle_cnt = 0; tbl_count = 0;
        n_alloc = 0; n_release = 0; n_ok = 0; n_nospace = 0; n_full = 0;
        max_count = 0; burst_left = 0; gap_left = 0;
        sender_hold = 0; rx_hold_req = 0; rx_hold_cnt = 0;
        rx_mode = 0; rx_mode_left = 0;
        win_base  = rtffa_pkg::BASE_RESET & ADDR_MAX;
        win_limit = rtffa_pkg::LIMIT_RESET & ADDR_MAX;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = rtffa_pkg::ACT_ALLOCATE;
        i_address = '0;
        i_length = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rtffa_pkg::CFG_WINDOW_BASE;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero length, page edges, huge size, empty and full releases
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        push_req(rtffa_pkg::ACT_ALLOCATE, ADDR_MAX, 1);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, rtffa_pkg::PAGE_BYTES);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, rtffa_pkg::PAGE_BYTES + 1);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, ADDR_MAX);
        push_req(rtffa_pkg::ACT_RELEASE, 0, 0);
        push_req(rtffa_pkg::ACT_RELEASE, rtffa_pkg::BASE_RESET + rtffa_pkg::PAGE_BYTES,
                 3 * rtffa_pkg::PAGE_BYTES);
        push_req(rtffa_pkg::ACT_RELEASE, 0, ADDR_MAX);
        push_req(rtffa_pkg::ACT_RELEASE, ADDR_MAX, ADDR_MAX);

        // Base zero: the first candidate is address zero, which is refused
        set_window(0, 64'h10_0000);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 100);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        // Base at the top: a zero length fits once, then the end saturates past it
        set_window(ADDR_MAX, ADDR_MAX);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        set_window(ADDR_MAX - 1, ADDR_MAX);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        push_req(rtffa_pkg::ACT_RELEASE, 0, ADDR_MAX);
        // Limit zero: nothing fits
        set_window(rtffa_pkg::PAGE_BYTES, 0);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 0);
        push_req(rtffa_pkg::ACT_ALLOCATE, 0, 1);

        // Default window, allocation heavy to reach table full; long receiver hold
        set_window(rtffa_pkg::BASE_RESET, rtffa_pkg::LIMIT_RESET);
        rx_hold_req = 1;
        random_phase(250, 85);
        // Tiny window: no space dominates
        set_window(64'h1000, 64'h8_0000);
        random_phase(220, 60);
        // Unaligned window bounds
        set_window(64'h1_2345, 64'h40_0777);
        random_phase(220, 65);
        // Whole address space, including wide random lengths
        set_window(0, ADDR_MAX);
        random_phase(230, 75);
        // Back to the defaults with a balanced mix
        set_window(rtffa_pkg::BASE_RESET, rtffa_pkg::LIMIT_RESET);
        random_phase(230, 70);
        drain();

        $display("covered %0d allocations and %0d releases across several window settings",
                 n_alloc, n_release);
        $display("results: %0d ok, %0d no space, %0d table full, peak table size %0d",
                 n_ok, n_nospace, n_full, max_count);
        if (fail_cnt == 0) begin
            $display("region_table_first_fit_allocator_core test passed");
        end else begin
            $display("region_table_first_fit_allocator_core test failed");
        end
        $finish;
    end
endmodule

// ===== region_table_first_fit_allocator_core.f =====
+incdir+hw/rtl
hw/rtl/rtffa_pkg.sv
hw/rtl/region_table_first_fit_allocator_core.sv
verif/tb_region_table_first_fit_allocator_core.sv
